// File: rtl/ntc_pkg.sv
`timescale 1ns / 1ps
// Package for the NTC sample to temperature converter.
// Holds widths, fixed-point constants, register indexes and the sequencer state type.
// No dependencies.
package ntc_pkg;

    localparam int unsigned SampleW = 12;
    localparam int unsigned TempW   = 17;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned LoW     = 28;
    localparam int unsigned RemW    = 24;
    localparam int unsigned DenW    = 23;
    localparam int unsigned MulAW   = 22;
    localparam int unsigned MulBW   = 20;
    localparam int unsigned ProdW   = MulAW + MulBW;
    localparam int unsigned CntW    = 5;

    localparam logic [CfgIdxW-1:0] CFG_LOW_SAMPLE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HIGH_SAMPLE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOW_TEMP    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_HIGH_TEMP   = 2'd3;

    localparam logic [SampleW-1:0]      RST_LOW_SAMPLE  = 12'd10;
    localparam logic [SampleW-1:0]      RST_HIGH_SAMPLE = 12'd4085;
    localparam logic signed [TempW-1:0] RST_LOW_TEMP    = -17'sd4000;
    localparam logic signed [TempW-1:0] RST_HIGH_TEMP   = 17'sd15000;

    localparam logic signed [MulAW-1:0] LN2_Q16        = 22'sd45426;
    localparam logic signed [MulBW-1:0] BETA_RECIP_Q30 = 20'sd271833;
    localparam logic signed [MulBW-1:0] RECIP3_Q17     = 20'sd43691;
    localparam logic signed [MulBW-1:0] RECIP5_Q18     = 20'sd52429;
    localparam logic signed [RemW-1:0]  T0_RECIP_Q30   = 24'sd3601343;
    localparam logic [RemW-1:0]         KDIV_REM0      = 24'd819200;
    localparam logic signed [TempW:0]   KELVIN_OFS     = 18'sd27315;
    localparam logic [16:0]             ONE_Q16        = 17'd65536;

    localparam logic [CntW-1:0] RDIV_STEPS = 5'd28;
    localparam logic [CntW-1:0] YDIV_STEPS = 5'd15;
    localparam logic [CntW-1:0] KDIV_STEPS = 5'd17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_NORM,
        S_YDIV,
        S_MYY,
        S_MY3,
        S_MY5,
        S_MQ3,
        S_MQ5,
        S_LN,
        S_MINV,
        S_INV,
        S_KDIV,
        S_SUB,
        S_DONE
    } t_state;

endpackage

// File: rtl/ntc_adc_to_celsius.sv
`timescale 1ns / 1ps
// NTC divider sample to temperature in hundredths of a degree Celsius.
// Shared restoring divider and shared signed multiplier under one sequencer.
// Depends on ntc_pkg.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------------
//  sample   | i_adc_valid  | o_adc_ready  | i_adc_sample
//  result   | o_temp_valid | i_temp_ready | o_temp_centi_celsius
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A fault request goes straight to the output load; a computed one runs through
// 28 ratio divider steps, the normalising shifts and a setup step, 15 series steps, the
// multiplier/sum states, 17 Kelvin steps, a subtract and the output load.
// Synchronous active-low reset restores the register defaults.
// Hold in the last state while the output register is full and not being read; take the
// next request as soon as the result moves into it.
module ntc_adc_to_celsius (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adc_valid,
    output logic                                o_adc_ready,
    input  logic [ntc_pkg::SampleW-1:0]         i_adc_sample,
    output logic                                o_temp_valid,
    input  logic                                i_temp_ready,
    output logic signed [ntc_pkg::TempW-1:0]    o_temp_centi_celsius,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ntc_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [ntc_pkg::TempW-1:0]           i_cfg_data
);

    ntc_pkg::t_state r_state, n_state;

    logic [ntc_pkg::SampleW-1:0]        r_low_sample, r_high_sample;
    logic signed [ntc_pkg::TempW-1:0]   r_low_temp, r_high_temp;

    logic [ntc_pkg::RemW-1:0]           r_rem, n_rem;
    logic [ntc_pkg::LoW-1:0]            r_lo, n_lo;
    logic [ntc_pkg::DenW-1:0]           r_den, n_den;
    logic [ntc_pkg::CntW-1:0]           r_cnt, n_cnt;
    logic signed [ntc_pkg::MulAW-1:0]   r_acc, n_acc;
    logic signed [15:0]                 r_y, n_y;
    logic signed [13:0]                 r_y2, n_y2;
    logic signed [13:0]                 r_y3, n_y3;
    logic signed [13:0]                 r_y5, n_y5;
    logic [11:0]                        r_q3, n_q3;
    logic signed [ntc_pkg::MulAW-1:0]   r_ln, n_ln;
    logic signed [ntc_pkg::TempW-1:0]   r_res, n_res;
    logic signed [ntc_pkg::ProdW-1:0]   r_prod;
    logic                               r_out_valid, n_out_valid;
    logic signed [ntc_pkg::TempW-1:0]   r_out_temp, n_out_temp;

    logic signed [ntc_pkg::MulAW-1:0]   mul_a;
    logic signed [ntc_pkg::MulBW-1:0]   mul_b;

    logic                   in_acc;
    logic                   low_hit, high_hit;
    logic                   out_free;
    logic                   last_step;
    logic                   x_small, x_large;
    logic [ntc_pkg::RemW:0] div_r2;
    logic [ntc_pkg::RemW:0] div_diff;
    logic                   div_ge;
    logic [16:0]            num_mag;
    logic signed [15:0]     y_w;
    logic signed [13:0]     prod_q16;
    logic signed [13:0]     neg_y3, neg_y5;
    logic [11:0]            q5_w;
    logic signed [ntc_pkg::MulAW-1:0] ln_sum;
    logic signed [ntc_pkg::RemW-1:0]  inv_t;
    logic signed [ntc_pkg::TempW:0]   cel_w;

    assign o_adc_ready          = (r_state == ntc_pkg::S_IDLE);
    assign o_temp_valid         = r_out_valid;
    assign o_temp_centi_celsius = r_out_temp;
    assign o_cfg_ready          = 1'b1;

    assign in_acc    = i_adc_valid && o_adc_ready;
    assign low_hit   = (i_adc_sample <= r_low_sample);
    assign high_hit  = (i_adc_sample >= r_high_sample);
    assign out_free  = !r_out_valid || i_temp_ready;
    assign last_step = (r_cnt == ntc_pkg::CntW'(1));
    assign x_small   = (r_lo[ntc_pkg::LoW-1:15] == '0);
    assign x_large   = |r_lo[ntc_pkg::LoW-1:16];

    assign div_r2   = {r_rem, r_lo[ntc_pkg::LoW-1]};
    assign div_diff = div_r2 - {2'b00, r_den};
    assign div_ge   = (div_r2 >= {2'b00, r_den});

    assign num_mag  = ntc_pkg::ONE_Q16 - {1'b0, r_lo[15:0]};
    assign y_w      = -$signed({1'b0, r_lo[14:0]});
    assign prod_q16 = r_prod[29:16];
    assign neg_y3   = -r_y3;
    assign neg_y5   = -r_y5;
    assign q5_w     = r_prod[29:18];
    assign ln_sum   = ntc_pkg::MulAW'(r_y)
                    - ntc_pkg::MulAW'($signed({1'b0, r_q3}))
                    - ntc_pkg::MulAW'($signed({1'b0, q5_w}));
    assign inv_t    = ntc_pkg::T0_RECIP_Q30 + $signed(r_prod[39:16]);
    assign cel_w    = $signed({1'b0, r_lo[16:0]}) - ntc_pkg::KELVIN_OFS;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ntc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (low_hit || high_hit) ? ntc_pkg::S_DONE : ntc_pkg::S_RDIV;
                end
            end
            ntc_pkg::S_RDIV: begin
                if (last_step) begin
                    n_state = ntc_pkg::S_NORM;
                end
            end
            ntc_pkg::S_NORM: begin
                if (!x_small && !x_large) begin
                    n_state = ntc_pkg::S_YDIV;
                end
            end
            ntc_pkg::S_YDIV: begin
                if (last_step) begin
                    n_state = ntc_pkg::S_MYY;
                end
            end
            ntc_pkg::S_MYY:  n_state = ntc_pkg::S_MY3;
            ntc_pkg::S_MY3:  n_state = ntc_pkg::S_MY5;
            ntc_pkg::S_MY5:  n_state = ntc_pkg::S_MQ3;
            ntc_pkg::S_MQ3:  n_state = ntc_pkg::S_MQ5;
            ntc_pkg::S_MQ5:  n_state = ntc_pkg::S_LN;
            ntc_pkg::S_LN:   n_state = ntc_pkg::S_MINV;
            ntc_pkg::S_MINV: n_state = ntc_pkg::S_INV;
            ntc_pkg::S_INV:  n_state = ntc_pkg::S_KDIV;
            ntc_pkg::S_KDIV: begin
                if (last_step) begin
                    n_state = ntc_pkg::S_SUB;
                end
            end
            ntc_pkg::S_SUB:  n_state = ntc_pkg::S_DONE;
            ntc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ntc_pkg::S_IDLE;
                end
            end
            default: n_state = ntc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rem       = r_rem;
        n_lo        = r_lo;
        n_den       = r_den;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_y         = r_y;
        n_y2        = r_y2;
        n_y3        = r_y3;
        n_y5        = r_y5;
        n_q3        = r_q3;
        n_ln        = r_ln;
        n_res       = r_res;
        n_out_temp  = r_out_temp;
        n_out_valid = r_out_valid && !i_temp_ready;
        mul_a       = '0;
        mul_b       = '0;
        case (r_state)
            ntc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (low_hit) begin
                        n_res = r_low_temp;
                    end else if (high_hit) begin
                        n_res = r_high_temp;
                    end
                    n_rem = '0;
                    n_lo  = {~i_adc_sample, 16'h0000};
                    n_den = ntc_pkg::DenW'(i_adc_sample);
                    n_cnt = ntc_pkg::RDIV_STEPS;
                    n_acc = '0;
                end
            end
            ntc_pkg::S_RDIV, ntc_pkg::S_YDIV, ntc_pkg::S_KDIV: begin
                n_rem = div_ge ? div_diff[ntc_pkg::RemW-1:0] : div_r2[ntc_pkg::RemW-1:0];
                n_lo  = {r_lo[ntc_pkg::LoW-2:0], div_ge};
                n_cnt = r_cnt - ntc_pkg::CntW'(1);
            end
            ntc_pkg::S_NORM: begin
                if (x_small) begin
                    n_lo  = r_lo << 1;
                    n_acc = r_acc - ntc_pkg::LN2_Q16;
                end else if (x_large) begin
                    n_lo  = r_lo >> 1;
                    n_acc = r_acc + ntc_pkg::LN2_Q16;
                end else begin
                    n_rem = ntc_pkg::RemW'({num_mag, 1'b0});
                    n_den = ntc_pkg::DenW'({1'b1, r_lo[15:0]});
                    n_lo  = '0;
                    n_cnt = ntc_pkg::YDIV_STEPS;
                end
            end
            ntc_pkg::S_MYY: begin
                n_y   = y_w;
                mul_a = ntc_pkg::MulAW'(y_w);
                mul_b = ntc_pkg::MulBW'(y_w);
            end
            ntc_pkg::S_MY3: begin
                n_y2  = prod_q16;
                mul_a = ntc_pkg::MulAW'(r_y);
                mul_b = ntc_pkg::MulBW'(prod_q16);
            end
            ntc_pkg::S_MY5: begin
                n_y3  = prod_q16;
                mul_a = ntc_pkg::MulAW'(prod_q16);
                mul_b = ntc_pkg::MulBW'(r_y2);
            end
            ntc_pkg::S_MQ3: begin
                n_y5  = prod_q16;
                mul_a = ntc_pkg::MulAW'(neg_y3);
                mul_b = ntc_pkg::RECIP3_Q17;
            end
            ntc_pkg::S_MQ5: begin
                n_q3  = r_prod[28:17];
                mul_a = ntc_pkg::MulAW'(neg_y5);
                mul_b = ntc_pkg::RECIP5_Q18;
            end
            ntc_pkg::S_LN: begin
                n_ln = r_acc + (ln_sum <<< 1);
            end
            ntc_pkg::S_MINV: begin
                mul_a = r_ln;
                mul_b = ntc_pkg::BETA_RECIP_Q30;
            end
            ntc_pkg::S_INV: begin
                n_rem = ntc_pkg::KDIV_REM0;
                n_den = inv_t[ntc_pkg::DenW-1:0];
                n_lo  = '0;
                n_cnt = ntc_pkg::KDIV_STEPS;
            end
            ntc_pkg::S_SUB: begin
                n_res = cel_w[ntc_pkg::TempW-1:0];
            end
            ntc_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_res;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_temp_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ntc_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_low_sample  <= ntc_pkg::RST_LOW_SAMPLE;
            r_high_sample <= ntc_pkg::RST_HIGH_SAMPLE;
            r_low_temp    <= ntc_pkg::RST_LOW_TEMP;
            r_high_temp   <= ntc_pkg::RST_HIGH_TEMP;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ntc_pkg::CFG_LOW_SAMPLE:  r_low_sample  <= i_cfg_data[ntc_pkg::SampleW-1:0];
                    ntc_pkg::CFG_HIGH_SAMPLE: r_high_sample <= i_cfg_data[ntc_pkg::SampleW-1:0];
                    ntc_pkg::CFG_LOW_TEMP:    r_low_temp    <= $signed(i_cfg_data);
                    ntc_pkg::CFG_HIGH_TEMP:   r_high_temp   <= $signed(i_cfg_data);
                    default: begin
                        r_low_sample <= r_low_sample;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_den      <= n_den;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_y        <= n_y;
        r_y2       <= n_y2;
        r_y3       <= n_y3;
        r_y5       <= n_y5;
        r_q3       <= n_q3;
        r_ln       <= n_ln;
        r_res      <= n_res;
        r_out_temp <= n_out_temp;
        r_prod     <= mul_a * mul_b;
    end

endmodule
